@@ design/xsr_pkg.sv @@
// xsr_pkg: types, constants, microcode program and generator functions
// for the xoshiro128** generator. No dependencies.
package xsr_pkg;

    typedef logic [31:0] word_t;
    typedef logic [3:0][31:0] gen_state_t;
    typedef logic [2:0] step_t;
    typedef logic [6:0] cnt_t;

    localparam gen_state_t STATE_RESET = {32'd3, 32'd7, 32'd4, 32'd1};
    localparam logic [127:0] LONG_POLY =
        {32'h1c580662, 32'hccf5a0ef, 32'h0b6f099f, 32'hb523952e};

    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_JUMP = 1'b1;

    typedef enum logic [1:0] {
        SEQ_WAIT_IN,
        SEQ_LOOP,
        SEQ_GOTO,
        SEQ_WAIT_OUT
    } seq_op_t;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_START,
        DP_DIV,
        DP_JUMP,
        DP_COMMIT,
        DP_EMIT
    } dp_cmd_t;

    localparam step_t STEP_IDLE   = 3'd0;
    localparam step_t STEP_DIV    = 3'd1;
    localparam step_t STEP_JUMP   = 3'd2;
    localparam step_t STEP_COMMIT = 3'd3;
    localparam step_t STEP_EMIT   = 3'd4;

    localparam cnt_t DIV_LAST  = 7'd31;
    localparam cnt_t JUMP_LAST = 7'd127;

    typedef struct packed {
        seq_op_t op;
        dp_cmd_t cmd;
        step_t   next_step;
        step_t   alt_step;
        cnt_t    limit;
    } ucode_t;

    typedef struct packed {
        dp_cmd_t cmd;
        cnt_t    cnt;
    } dp_ctl_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

    // next_step: draw / loop exit; alt_step: jump branch
    function automatic ucode_t ucode_rom(input step_t s);
        ucode_t u;
        begin
            case (s)
                STEP_IDLE:   u = '{SEQ_WAIT_IN, DP_START, STEP_DIV, STEP_JUMP, '0};
                STEP_DIV:    u = '{SEQ_LOOP, DP_DIV, STEP_EMIT, STEP_IDLE, DIV_LAST};
                STEP_JUMP:   u = '{SEQ_LOOP, DP_JUMP, STEP_COMMIT, STEP_IDLE, JUMP_LAST};
                STEP_COMMIT: u = '{SEQ_GOTO, DP_COMMIT, STEP_EMIT, STEP_IDLE, '0};
                STEP_EMIT:   u = '{SEQ_WAIT_OUT, DP_EMIT, STEP_IDLE, STEP_IDLE, '0};
                default:     u = '{SEQ_GOTO, DP_NOP, STEP_IDLE, STEP_IDLE, '0};
            endcase
            return u;
        end
    endfunction

    // rotl(w1 * 5, 7) * 9 with shift-adds
    function automatic word_t scramble(input word_t w1);
        word_t t;
        word_t r;
        begin
            t = w1 + {w1[29:0], 2'b00};
            r = {t[24:0], t[31:25]};
            return r + {r[28:0], 3'b000};
        end
    endfunction

    function automatic gen_state_t advance(input gen_state_t s);
        gen_state_t n;
        begin
            n    = s;
            n[2] = s[2] ^ s[0];
            n[3] = s[3] ^ s[1];
            n[1] = s[1] ^ n[2];
            n[0] = s[0] ^ n[3];
            n[2] = n[2] ^ {s[1][22:0], 9'b0};
            n[3] = {n[3][20:0], n[3][31:21]};
            return n;
        end
    endfunction

endpackage

@@ design/xsr_if.sv @@
// Request and response word channels of the xoshiro128** generator.
// Depends on nothing.
interface xsr_req_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] bound;

    modport source (output valid, output op, output bound, input ready);
    modport sink   (input valid, input op, input bound, output ready);
endinterface

interface xsr_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic [31:0] raw;
    logic        was_jump;

    modport source (output valid, output value, output raw, output was_jump, input ready);
    modport sink   (input valid, input value, input raw, input was_jump, output ready);
endinterface

@@ design/xoshiro128_starstar_generator.sv @@
// Draw: accept step plus 32 remainder steps in the sequencer loop, then
// output; the next request is taken only once the output step is done.
// Long jump: accept step, 128 jump steps and a commit step, then output.
// A new request is taken while a result waits in the output register.
// Reset: state words 1,4,7,3, sequencer idle, no result pending.
module xoshiro128_starstar_generator (
    input  logic    clk,
    input  logic    rst_n,
    xsr_req_if.sink   req,
    xsr_rsp_if.source rsp
);

    xsr_pkg::dp_ctl_t  ctl;
    xsr_pkg::dp_stat_t stat;

    xsr_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_op    (req.op),
        .in_ready (req.ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    xsr_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .in_op        (req.op),
        .in_bound     (req.bound),
        .stat         (stat),
        .out_ready    (rsp.ready),
        .out_valid    (rsp.valid),
        .out_value    (rsp.value),
        .out_raw      (rsp.raw),
        .out_was_jump (rsp.was_jump)
    );

endmodule

@@ design/xsr_sequencer.sv @@
// xsr_sequencer: step counter, loop counter and microcode ROM that drive
// the datapath. Depends on xsr_pkg.
module xsr_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_op,
    output logic              in_ready,
    input  xsr_pkg::dp_stat_t stat,
    output xsr_pkg::dp_ctl_t  ctl
);

    xsr_pkg::step_t  step_reg;
    xsr_pkg::step_t  step_next;
    xsr_pkg::cnt_t   cnt_reg;
    xsr_pkg::cnt_t   cnt_next;
    xsr_pkg::ucode_t uw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= xsr_pkg::STEP_IDLE;
            cnt_reg  <= '0;
        end
        else
        begin
            step_reg <= step_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_comb
    begin
        uw        = xsr_pkg::ucode_rom(step_reg);
        step_next = step_reg;
        cnt_next  = cnt_reg;
        in_ready  = 1'b0;
        ctl.cmd   = xsr_pkg::DP_NOP;
        ctl.cnt   = cnt_reg;
        case (uw.op)
            xsr_pkg::SEQ_WAIT_IN:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.cmd   = uw.cmd;
                    cnt_next  = '0;
                    step_next = (in_op == xsr_pkg::OP_JUMP) ? uw.alt_step : uw.next_step;
                end
            end
            xsr_pkg::SEQ_LOOP:
            begin
                ctl.cmd = uw.cmd;
                if (cnt_reg == uw.limit)
                begin
                    cnt_next  = '0;
                    step_next = uw.next_step;
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            xsr_pkg::SEQ_GOTO:
            begin
                ctl.cmd   = uw.cmd;
                step_next = uw.next_step;
            end
            xsr_pkg::SEQ_WAIT_OUT:
            begin
                if (stat.out_free)
                begin
                    ctl.cmd   = uw.cmd;
                    step_next = uw.next_step;
                end
            end
            default:
            begin
                step_next = xsr_pkg::STEP_IDLE;
            end
        endcase
    end

endmodule

@@ design/xsr_datapath.sv @@
// xsr_datapath: generator state, jump accumulator, bit-serial remainder
// unit and output register. Depends on xsr_pkg.
module xsr_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  xsr_pkg::dp_ctl_t  ctl,
    input  logic              in_op,
    input  logic [31:0]       in_bound,
    output xsr_pkg::dp_stat_t stat,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [31:0]       out_value,
    output logic [31:0]       out_raw,
    output logic              out_was_jump
);

    xsr_pkg::gen_state_t state_reg, state_next;
    xsr_pkg::gen_state_t acc_reg, acc_next;
    xsr_pkg::word_t      bound_reg, bound_next;
    xsr_pkg::word_t      rem_reg, rem_next;
    xsr_pkg::word_t      quo_reg, quo_next;
    xsr_pkg::word_t      raw_reg, raw_next;
    logic                jump_reg, jump_next;
    logic                out_valid_reg, out_valid_next;
    xsr_pkg::word_t      out_value_reg, out_value_next;
    xsr_pkg::word_t      out_raw_reg, out_raw_next;
    logic                out_jump_reg, out_jump_next;

    logic [32:0]         shifted;
    logic [33:0]         diff;

    assign shifted      = {rem_reg, quo_reg[31]};
    assign diff         = {1'b0, shifted} - {2'b00, bound_reg};
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign out_value    = out_value_reg;
    assign out_raw      = out_raw_reg;
    assign out_was_jump = out_jump_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= xsr_pkg::STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg       <= acc_next;
        bound_reg     <= bound_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        raw_reg       <= raw_next;
        jump_reg      <= jump_next;
        out_value_reg <= out_value_next;
        out_raw_reg   <= out_raw_next;
        out_jump_reg  <= out_jump_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        bound_next     = bound_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        raw_next       = raw_reg;
        jump_next      = jump_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_value_next = out_value_reg;
        out_raw_next   = out_raw_reg;
        out_jump_next  = out_jump_reg;
        case (ctl.cmd)
            xsr_pkg::DP_START:
            begin
                jump_next  = in_op;
                bound_next = in_bound;
                if (in_op == xsr_pkg::OP_DRAW)
                begin
                    raw_next   = xsr_pkg::scramble(state_reg[1]);
                    quo_next   = raw_next;
                    rem_next   = '0;
                    state_next = xsr_pkg::advance(state_reg);
                end
                else
                begin
                    acc_next = '0;
                end
            end
            xsr_pkg::DP_DIV:
            begin
                rem_next = diff[33] ? shifted[31:0] : diff[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            xsr_pkg::DP_JUMP:
            begin
                if (xsr_pkg::LONG_POLY[ctl.cnt])
                begin
                    acc_next = acc_reg ^ state_reg;
                end
                state_next = xsr_pkg::advance(state_reg);
            end
            xsr_pkg::DP_COMMIT:
            begin
                state_next = acc_reg;
            end
            xsr_pkg::DP_EMIT:
            begin
                out_valid_next = 1'b1;
                out_jump_next  = jump_reg;
                if (jump_reg == xsr_pkg::OP_JUMP)
                begin
                    out_value_next = '0;
                    out_raw_next   = '0;
                end
                else
                begin
                    out_value_next = (bound_reg == '0) ? '0 : rem_reg;
                    out_raw_next   = raw_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule
